// ===== hw/rtl/video_base_and_fetch_counter_macros.svh =====
// Assertion macros for the video base and fetch counter block.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef VIDEO_BASE_AND_FETCH_COUNTER_MACROS_SVH
`define VIDEO_BASE_AND_FETCH_COUNTER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define VBFC_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("vbfc assertion failed");

// Next-cycle implication, checked outside reset.
`define VBFC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("vbfc assertion failed");

`endif

// ===== hw/rtl/vbfc_pkg.sv =====
// Package for the video base and fetch counter block.
// Holds the transfer payload types, item kind codes and register offsets; no dependencies.
package vbfc_pkg;

  typedef enum logic [2:0] {
    KIND_BYTE_RD  = 3'd0,
    KIND_BYTE_WR  = 3'd1,
    KIND_WORD_RD  = 3'd2,
    KIND_WORD_WR  = 3'd3,
    KIND_VSYNC    = 3'd4,
    KIND_TICK     = 3'd5,
    KIND_ENABLE   = 3'd6
  } kind_e;

  localparam logic [5:0] OFF_BASE_HI = 6'h01;
  localparam logic [5:0] OFF_BASE_MID = 6'h03;
  localparam logic [5:0] OFF_CNT_HI = 6'h05;
  localparam logic [5:0] OFF_CNT_MID = 6'h07;
  localparam logic [5:0] OFF_CNT_LO = 6'h09;
  localparam logic [5:0] OFF_SYNC = 6'h0a;

  localparam int WINDOW_BYTES = 64;
  localparam logic [1:0] FETCH_PHASE = 2'd2;
  localparam logic [23:0] FETCH_STEP = 24'd2;

  typedef struct packed {
    logic [2:0]  kind;
    logic [5:0]  offset;
    logic [15:0] write_data;
    logic        enable;
  } in_item_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic        address_error;
    logic        error_on_write;
    logic        fetch_valid;
    logic [23:0] fetch_address;
    logic        sync_select;
  } out_item_t;

endpackage

// ===== hw/rtl/vbfc_core.sv =====
// State registers and per-item logic of the video base and fetch counter block.
// Depends on vbfc_pkg for the item types, kind codes and register offsets.
module vbfc_core #(
  parameter int LOAD_DELAY = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  vbfc_pkg::in_item_t  item_i,
  output vbfc_pkg::out_item_t result_o
);

  logic [15:0]           base_q, base_d;
  logic [23:0]           counter_q, counter_d;
  logic [7:0]            sync_q, sync_d;
  logic [1:0]            phase_q, phase_d;
  logic [LOAD_DELAY-1:0] delay_q, delay_d;
  logic                  de_q, de_d;
  logic                  load_active;
  logic [5:0]            off_lo;
  vbfc_pkg::out_item_t   res;

  function automatic logic [7:0] window_byte(input logic [5:0] off, input logic [15:0] base,
                                             input logic [23:0] cnt, input logic [7:0] sync);
    logic [7:0] val;
    val = 8'h00;
    if (int'(off) < vbfc_pkg::WINDOW_BYTES) begin
      unique case (off)
        vbfc_pkg::OFF_BASE_HI:  val = base[15:8];
        vbfc_pkg::OFF_BASE_MID: val = base[7:0];
        vbfc_pkg::OFF_CNT_HI:   val = cnt[23:16];
        vbfc_pkg::OFF_CNT_MID:  val = cnt[15:8];
        vbfc_pkg::OFF_CNT_LO:   val = cnt[7:0];
        vbfc_pkg::OFF_SYNC:     val = sync;
        default:                val = 8'h00;
      endcase
    end
    return val;
  endfunction

  assign off_lo = item_i.offset | 6'd1;

  always_comb begin
    base_d      = base_q;
    counter_d   = counter_q;
    sync_d      = sync_q;
    phase_d     = phase_q;
    delay_d     = delay_q;
    de_d        = de_q;
    load_active = 1'b0;
    res         = '0;

    unique case (vbfc_pkg::kind_e'(item_i.kind)) inside
      vbfc_pkg::KIND_BYTE_RD: begin
        res.read_data = {8'h00, window_byte(item_i.offset, base_q, counter_q, sync_q)};
      end
      vbfc_pkg::KIND_BYTE_WR, vbfc_pkg::KIND_WORD_WR: begin
        if (item_i.kind == vbfc_pkg::KIND_WORD_WR && item_i.offset[0]) begin
          res.address_error  = 1'b1;
          res.error_on_write = 1'b1;
        end else begin
          if (item_i.kind == vbfc_pkg::KIND_BYTE_WR) begin
            if (int'(item_i.offset) < vbfc_pkg::WINDOW_BYTES) begin
              unique case (item_i.offset)
                vbfc_pkg::OFF_BASE_HI:  base_d[15:8] = item_i.write_data[7:0];
                vbfc_pkg::OFF_BASE_MID: base_d[7:0]  = item_i.write_data[7:0];
                vbfc_pkg::OFF_SYNC:     sync_d       = item_i.write_data[7:0];
                default: ;
              endcase
            end
          end else begin
            // The even byte takes the high half and the odd byte the low half.
            if (int'(item_i.offset) < vbfc_pkg::WINDOW_BYTES) begin
              unique case (item_i.offset)
                vbfc_pkg::OFF_SYNC: sync_d = item_i.write_data[15:8];
                default: ;
              endcase
            end
            if (int'(off_lo) < vbfc_pkg::WINDOW_BYTES) begin
              unique case (off_lo)
                vbfc_pkg::OFF_BASE_HI:  base_d[15:8] = item_i.write_data[7:0];
                vbfc_pkg::OFF_BASE_MID: base_d[7:0]  = item_i.write_data[7:0];
                default: ;
              endcase
            end
          end
        end
      end
      vbfc_pkg::KIND_WORD_RD: begin
        if (item_i.offset[0]) begin
          res.address_error = 1'b1;
        end else begin
          res.read_data = {window_byte(item_i.offset, base_q, counter_q, sync_q),
                           window_byte(off_lo, base_q, counter_q, sync_q)};
        end
      end
      vbfc_pkg::KIND_VSYNC: begin
        counter_d = {base_q, 8'h00};
      end
      vbfc_pkg::KIND_TICK: begin
        delay_d[0] = de_q;
        for (int k = 1; k < LOAD_DELAY; k++) begin
          delay_d[k] = delay_q[k-1];
        end
        load_active = delay_d[LOAD_DELAY-1];
        if (phase_q == vbfc_pkg::FETCH_PHASE && load_active) begin
          res.fetch_valid   = 1'b1;
          res.fetch_address = counter_q;
          counter_d         = counter_q + vbfc_pkg::FETCH_STEP;
        end
        phase_d = phase_q + 2'd1;
      end
      vbfc_pkg::KIND_ENABLE: begin
        de_d = item_i.enable;
      end
      default: ;
    endcase

    res.sync_select = sync_d[1];
  end

  assign result_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q    <= '0;
      counter_q <= '0;
      sync_q    <= '0;
      phase_q   <= '0;
      delay_q   <= '0;
      de_q      <= 1'b0;
    end else if (step_i) begin
      base_q    <= base_d;
      counter_q <= counter_d;
      sync_q    <= sync_d;
      phase_q   <= phase_d;
      delay_q   <= delay_d;
      de_q      <= de_d;
    end
  end

endmodule

// ===== hw/rtl/video_base_and_fetch_counter.sv =====
// Top level of the video base and fetch counter block: input register, result register.
// Depends on vbfc_pkg, vbfc_core and video_base_and_fetch_counter_macros.svh.
//
//   channel | direction | handshake               | payload
//   in      | input     | in_valid_i / in_ready_o  | in_data_i  (vbfc_pkg::in_item_t)
//   out     | output    | out_valid_o / out_ready_i | out_data_o (vbfc_pkg::out_item_t)
//
// One item is taken per cycle while the output is not stalled; its result is registered in the result register.
// The state update and result logic sit between the input register and the result register.
// Reset clears the valid flags and core state at once, so items are taken as soon as reset is released.
// While out_ready_i is low the result holds and one more item waits in the input register.
`include "video_base_and_fetch_counter_macros.svh"

module video_base_and_fetch_counter #(
  parameter int LOAD_DELAY = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  vbfc_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output vbfc_pkg::out_item_t out_data_o
);

  logic                s1_valid_q;
  vbfc_pkg::in_item_t  s1_item_q;
  logic                out_valid_q;
  vbfc_pkg::out_item_t out_data_q;
  vbfc_pkg::out_item_t result;
  logic                advance;

  assign advance    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;

  vbfc_core #(
    .LOAD_DELAY(LOAD_DELAY)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (advance),
    .item_i  (s1_item_q),
    .result_o(result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_item_q <= in_data_i;
    end
    if (advance) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `VBFC_ASSERT_NEXT(a_advance_fills_out, advance, out_valid_o)
  `VBFC_ASSERT_SAME(a_stall_only_when_full, !in_ready_o, s1_valid_q && out_valid_o && !out_ready_i)
  `VBFC_ASSERT_SAME(a_write_err_has_err, out_valid_o && out_data_o.error_on_write, out_data_o.address_error)
  `VBFC_ASSERT_SAME(a_fetch_no_err, out_valid_o && out_data_o.fetch_valid, !out_data_o.address_error)

endmodule
